/* design/phca_pkg.sv */
// phca_pkg: shared constants, types and control bundles of the pixel hit
// cluster assigner
// depends on nothing; imported by every module of the block
package phca_pkg;

  // sizing of the per-chip stores
  localparam int NUM_CHIPS = 48;
  localparam int MAX_HITS  = 64;

  // fixed field widths
  localparam int CHIP_W  = 6;
  localparam int COL_W   = 10;
  localparam int ROW_W   = 9;
  localparam int TAG_W   = 16;
  localparam int LIM_W   = 4;
  localparam int LABEL_W = 6;
  localparam int CNT_W   = 7;

  // derived address widths
  localparam int CHIP_AW  = (NUM_CHIPS > 1) ? $clog2(NUM_CHIPS) : 1;
  localparam int HIT_AW   = $clog2(MAX_HITS);
  localparam int HS_AW    = CHIP_AW + HIT_AW;
  localparam int HS_DEPTH = NUM_CHIPS * (2 ** HIT_AW);

  localparam logic [LIM_W-1:0] LIMIT_RST = LIM_W'(2);

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_SCAN,
    S_UPDATE,
    S_DONE
  } state_e;

  // one stored hit
  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [HIT_AW-1:0] label;
  } hit_entry_t;

  // per-chip event bookkeeping
  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [CNT_W-1:0] hits;
    logic [CNT_W-1:0] clusters;
  } chip_entry_t;

  // hit and cluster-size store controls
  typedef struct packed {
    logic [CHIP_AW-1:0] chip;
    logic               rd_en;
    logic [HIT_AW-1:0]  rd_idx;
    logic               wr_en;
    logic [HIT_AW-1:0]  wr_idx;
    hit_entry_t         wr_entry;
    logic               sz_rd_en;
    logic [HIT_AW-1:0]  sz_rd_lbl;
    logic               sz_wr_en;
    logic [HIT_AW-1:0]  sz_wr_lbl;
    logic [CNT_W-1:0]   sz_wr_val;
  } hs_ctrl_t;

  // chip table controls
  typedef struct packed {
    logic               rd_en;
    logic [CHIP_AW-1:0] rd_chip;
    logic               wr_en;
    logic [CHIP_AW-1:0] wr_chip;
    chip_entry_t        wr_entry;
  } ct_ctrl_t;

  // one result word
  typedef struct packed {
    logic [CHIP_W-1:0]  chip;
    logic [LABEL_W-1:0] label;
    logic [CNT_W-1:0]   size;
    logic [CNT_W-1:0]   hits;
    logic [CNT_W-1:0]   clusters;
    logic               fresh;
    logic               ovf;
  } result_t;

endpackage

/* design/pixel_hit_cluster_assigner_core.sv */
// pixel_hit_cluster_assigner_core: top level, sequencer and result register
// depends on phca_pkg, phca_match, phca_hit_store, phca_chip_table
//
// channel  | direction | handshake                 | payload
// ---------+-----------+---------------------------+------------------------------
// hit in   | input     | in_valid_i / in_ready_o   | chip_id, column, pixel_row,
//          |           |                           | event_tag
// result   | output    | out_valid_o / out_ready_i | chip_out, cluster_label, ...
// config   | input     | cfg_we_i                  | cfg_wdata_i (neighbor_limit)
//
// a hit that scans stored hits passes from lookup through scan and update to
// done, where its word enters the result register; new event, full store and
// unknown chip go from lookup straight to done; the next hit is accepted once
// the sequencer is back in idle; the scan reads one stored hit per cycle into
// the compare unit, at most MAX_HITS - 1 of them
// reset clears the sequencer and the active flags and sets the limit to LIMIT_RST; no clearing pass
// a waiting result does not block the next hit; a full result register holds
// the sequencer in its last state
module pixel_hit_cluster_assigner_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [phca_pkg::LIM_W-1:0]      cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [phca_pkg::CHIP_W-1:0]     chip_id_i,
  input  logic [phca_pkg::COL_W-1:0]      column_i,
  input  logic [phca_pkg::ROW_W-1:0]      pixel_row_i,
  input  logic [phca_pkg::TAG_W-1:0]      event_tag_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [phca_pkg::CHIP_W-1:0]     chip_out_o,
  output logic [phca_pkg::LABEL_W-1:0]    cluster_label_o,
  output logic [phca_pkg::CNT_W-1:0]      cluster_size_o,
  output logic [phca_pkg::CNT_W-1:0]      hits_in_event_o,
  output logic [phca_pkg::CNT_W-1:0]      clusters_in_event_o,
  output logic                            new_cluster_o,
  output logic                            overflow_o
);
  import phca_pkg::*;

  state_e            state_q, state_d;
  logic [LIM_W-1:0]  limit_q;
  logic [CHIP_W-1:0] chip_q;
  logic [COL_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;
  logic [TAG_W-1:0]  tag_q;
  logic [CNT_W-1:0]  n_q, n_d;
  logic [CNT_W-1:0]  clu_q, clu_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic              pend_q, pend_d;
  logic              found_q, found_d;
  logic [HIT_AW-1:0] label_q, label_d;
  result_t           res_q, res_d;
  result_t           out_q, out_d;
  logic              out_valid_q, out_valid_d;

  hs_ctrl_t          hs_ctrl;
  ct_ctrl_t          ct_ctrl;
  hit_entry_t        hs_rdata;
  logic [CNT_W-1:0]  sz_rdata;
  chip_entry_t       ct_rdata;
  logic              ct_active;
  logic              match;

  logic              in_fire;
  logic              chip_ok;
  logic              new_event;
  logic              full;
  logic              hit_now;
  logic [CNT_W-1:0]  size_new;
  logic [CNT_W-1:0]  clu_new;

  // submodules
  phca_match u_match (
    .col_i     (col_q),
    .row_i     (row_q),
    .ref_col_i (hs_rdata.col),
    .ref_row_i (hs_rdata.row),
    .limit_i   (limit_q),
    .match_o   (match)
  );

  phca_hit_store u_hit_store (
    .clk_i      (clk_i),
    .ctrl_i     (hs_ctrl),
    .rdata_o    (hs_rdata),
    .sz_rdata_o (sz_rdata)
  );

  phca_chip_table u_chip_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ct_ctrl),
    .rdata_o  (ct_rdata),
    .active_o (ct_active)
  );

  // status decode
  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign chip_ok    = (int'(chip_q) < NUM_CHIPS);
  assign new_event  = !ct_active || (ct_rdata.tag != tag_q);
  assign full       = (int'(ct_rdata.hits) >= MAX_HITS);
  assign hit_now    = pend_q && match;
  assign size_new   = found_q ? (sz_rdata + CNT_W'(1)) : CNT_W'(1);
  assign clu_new    = found_q ? clu_q : (clu_q + CNT_W'(1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_LOOKUP;
      end
      S_LOOKUP: begin
        if (!chip_ok || new_event || full) state_d = S_DONE;
        else state_d = S_SCAN;
      end
      S_SCAN: begin
        if (hit_now || (idx_q == '0)) state_d = S_UPDATE;
      end
      S_UPDATE: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // sequencer outputs and datapath next values
  always_comb begin
    hs_ctrl      = '0;
    hs_ctrl.chip = CHIP_AW'(chip_q);
    ct_ctrl      = '0;
    n_d          = n_q;
    clu_d        = clu_q;
    idx_d        = idx_q;
    pend_d       = pend_q;
    found_d      = found_q;
    label_d      = label_q;
    res_d        = res_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q;

    // result word leaves
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        ct_ctrl.rd_en   = in_valid_i && (int'(chip_id_i) < NUM_CHIPS);
        ct_ctrl.rd_chip = CHIP_AW'(chip_id_i);
      end
      S_LOOKUP: begin
        res_d      = '0;
        res_d.chip = chip_q;
        if (chip_ok) begin
          if (new_event) begin
            // first hit of an event clears the chip and opens cluster 0
            hs_ctrl.wr_en          = 1'b1;
            hs_ctrl.wr_idx         = '0;
            hs_ctrl.wr_entry.col   = col_q;
            hs_ctrl.wr_entry.row   = row_q;
            hs_ctrl.wr_entry.label = '0;
            hs_ctrl.sz_wr_en       = 1'b1;
            hs_ctrl.sz_wr_lbl      = '0;
            hs_ctrl.sz_wr_val      = CNT_W'(1);
            ct_ctrl.wr_en          = 1'b1;
            ct_ctrl.wr_chip        = CHIP_AW'(chip_q);
            ct_ctrl.wr_entry.tag   = tag_q;
            ct_ctrl.wr_entry.hits  = CNT_W'(1);
            ct_ctrl.wr_entry.clusters = CNT_W'(1);
            res_d.size     = CNT_W'(1);
            res_d.hits     = CNT_W'(1);
            res_d.clusters = CNT_W'(1);
            res_d.fresh    = 1'b1;
          end else if (full) begin
            // store full, hit dropped
            res_d.hits     = ct_rdata.hits;
            res_d.clusters = ct_rdata.clusters;
            res_d.ovf      = 1'b1;
          end else begin
            n_d     = ct_rdata.hits;
            clu_d   = ct_rdata.clusters;
            idx_d   = ct_rdata.hits;
            pend_d  = 1'b0;
            found_d = 1'b0;
          end
        end
      end
      S_SCAN: begin
        if (hit_now) begin
          // neighbor found, fetch its cluster size
          found_d           = 1'b1;
          label_d           = hs_rdata.label;
          hs_ctrl.sz_rd_en  = 1'b1;
          hs_ctrl.sz_rd_lbl = hs_rdata.label;
        end else if (idx_q == '0) begin
          found_d = 1'b0;
          label_d = HIT_AW'(clu_q);
        end else begin
          // read the next older hit, compare it next cycle
          hs_ctrl.rd_en  = 1'b1;
          hs_ctrl.rd_idx = HIT_AW'(idx_q - CNT_W'(1));
          idx_d          = idx_q - CNT_W'(1);
          pend_d         = 1'b1;
        end
      end
      S_UPDATE: begin
        hs_ctrl.wr_en             = 1'b1;
        hs_ctrl.wr_idx            = HIT_AW'(n_q);
        hs_ctrl.wr_entry.col      = col_q;
        hs_ctrl.wr_entry.row      = row_q;
        hs_ctrl.wr_entry.label    = label_q;
        hs_ctrl.sz_wr_en          = 1'b1;
        hs_ctrl.sz_wr_lbl         = label_q;
        hs_ctrl.sz_wr_val         = size_new;
        ct_ctrl.wr_en             = 1'b1;
        ct_ctrl.wr_chip           = CHIP_AW'(chip_q);
        ct_ctrl.wr_entry.tag      = tag_q;
        ct_ctrl.wr_entry.hits     = n_q + CNT_W'(1);
        ct_ctrl.wr_entry.clusters = clu_new;
        res_d.chip     = chip_q;
        res_d.label    = LABEL_W'(label_q);
        res_d.size     = size_new;
        res_d.hits     = n_q + CNT_W'(1);
        res_d.clusters = clu_new;
        res_d.fresh    = !found_q;
        res_d.ovf      = 1'b0;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      limit_q     <= LIMIT_RST;
      pend_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
      if (cfg_we_i) limit_q <= cfg_wdata_i;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      chip_q <= chip_id_i;
      col_q  <= column_i;
      row_q  <= pixel_row_i;
      tag_q  <= event_tag_i;
    end
    n_q     <= n_d;
    clu_q   <= clu_d;
    idx_q   <= idx_d;
    found_q <= found_d;
    label_q <= label_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  // result ports
  assign out_valid_o         = out_valid_q;
  assign chip_out_o          = out_q.chip;
  assign cluster_label_o     = out_q.label;
  assign cluster_size_o      = out_q.size;
  assign hits_in_event_o     = out_q.hits;
  assign clusters_in_event_o = out_q.clusters;
  assign new_cluster_o       = out_q.fresh;
  assign overflow_o          = out_q.ovf;

`ifndef SYNTH
  // an accepted hit always goes to the chip lookup
  a_accept_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == S_LOOKUP))
    else $error("accepted hit did not enter lookup");

  // a dropped hit carries no cluster
  a_ovf_no_cluster: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && overflow_o) |-> (!new_cluster_o && (cluster_size_o == '0)))
    else $error("dropped hit reports a cluster");

  // a stored hit's label lies below the cluster count
  a_label_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !overflow_o && (int'(chip_out_o) < NUM_CHIPS))
      |-> (CNT_W'(cluster_label_o) < clusters_in_event_o))
    else $error("cluster label beyond cluster count");

  // never more clusters than hits
  a_clusters_le_hits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (clusters_in_event_o <= hits_in_event_o))
    else $error("more clusters than hits");

  // scan only runs within the chip's stored hits
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (idx_q <= n_q))
    else $error("scan index beyond hit count");
`endif

endmodule

/* design/phca_match.sv */
// phca_match: shared neighbor compare unit, one stored hit per use
// depends on phca_pkg
module phca_match (
  input  logic [phca_pkg::COL_W-1:0] col_i,
  input  logic [phca_pkg::ROW_W-1:0] row_i,
  input  logic [phca_pkg::COL_W-1:0] ref_col_i,
  input  logic [phca_pkg::ROW_W-1:0] ref_row_i,
  input  logic [phca_pkg::LIM_W-1:0] limit_i,
  output logic                       match_o
);
  import phca_pkg::*;

  logic [COL_W-1:0] dcol;
  logic [ROW_W-1:0] drow;

  // absolute distances
  assign dcol = (col_i > ref_col_i) ? (col_i - ref_col_i) : (ref_col_i - col_i);
  assign drow = (row_i > ref_row_i) ? (row_i - ref_row_i) : (ref_row_i - row_i);

  // both distances strictly below the limit
  assign match_o = (dcol < COL_W'(limit_i)) && (drow < ROW_W'(limit_i));

endmodule

/* design/phca_hit_store.sv */
// phca_hit_store: per-chip hit memory and cluster size memory
// depends on phca_pkg
module phca_hit_store (
  input  logic                          clk_i,
  input  phca_pkg::hs_ctrl_t            ctrl_i,
  output phca_pkg::hit_entry_t          rdata_o,
  output logic [phca_pkg::CNT_W-1:0]    sz_rdata_o
);
  import phca_pkg::*;

  hit_entry_t       hit_mem [HS_DEPTH];
  logic [CNT_W-1:0] size_mem [HS_DEPTH];
  hit_entry_t       rdata_q;
  logic [CNT_W-1:0] sz_rdata_q;

  logic [HS_AW-1:0] hit_rd_addr, hit_wr_addr, sz_rd_addr, sz_wr_addr;

  // chip selects the row of entries
  assign hit_rd_addr = {ctrl_i.chip, ctrl_i.rd_idx};
  assign hit_wr_addr = {ctrl_i.chip, ctrl_i.wr_idx};
  assign sz_rd_addr  = {ctrl_i.chip, ctrl_i.sz_rd_lbl};
  assign sz_wr_addr  = {ctrl_i.chip, ctrl_i.sz_wr_lbl};

  // hit memory, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      hit_mem[hit_wr_addr] <= ctrl_i.wr_entry;
    end
    if (ctrl_i.rd_en) begin
      rdata_q <= hit_mem[hit_rd_addr];
    end
  end

  // cluster size memory
  always_ff @(posedge clk_i) begin
    if (ctrl_i.sz_wr_en) begin
      size_mem[sz_wr_addr] <= ctrl_i.sz_wr_val;
    end
    if (ctrl_i.sz_rd_en) begin
      sz_rdata_q <= size_mem[sz_rd_addr];
    end
  end

  assign rdata_o    = rdata_q;
  assign sz_rdata_o = sz_rdata_q;

endmodule

/* design/phca_chip_table.sv */
// phca_chip_table: per-chip event tag and counts, plus active flags
// depends on phca_pkg
module phca_chip_table (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  phca_pkg::ct_ctrl_t    ctrl_i,
  output phca_pkg::chip_entry_t rdata_o,
  output logic                  active_o
);
  import phca_pkg::*;

  chip_entry_t          entry_mem [NUM_CHIPS];
  chip_entry_t          rdata_q;
  logic [NUM_CHIPS-1:0] active_q;
  logic                 active_rd_q;

  // active flags, cleared by reset, set on any write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else if (ctrl_i.wr_en) begin
      active_q[ctrl_i.wr_chip] <= 1'b1;
    end
  end

  // entry memory with registered read
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      entry_mem[ctrl_i.wr_chip] <= ctrl_i.wr_entry;
    end
    if (ctrl_i.rd_en) begin
      rdata_q     <= entry_mem[ctrl_i.rd_chip];
      active_rd_q <= active_q[ctrl_i.rd_chip];
    end
  end

  assign rdata_o  = rdata_q;
  assign active_o = active_rd_q;

endmodule
